// ===== sv/ertc_pkg.sv =====
// Package for the epoch-seconds to RTC calendar converter.
// Holds the command and status types, register indexes and calendar helpers.
// Used by the controller, the datapath and the top level.
package ertc_pkg;

	localparam int unsigned DaysPlainYear = 28 + 30 * 4 + 31 * 7;
	// Each divide pass is two steps: a reciprocal multiply, then the remainder.
	localparam int unsigned DivSteps = 2;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 18;
	localparam int unsigned RESULT_W = 48;
	localparam int unsigned DAYS_W = 16;
	localparam int unsigned CNT_W = $clog2(DivSteps);

	localparam logic [DAYS_W-1:0] DAYS_PLAIN = DAYS_W'(DaysPlainYear);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DivSteps - 1);

	// Rounded-up reciprocals, exact for every 32-bit dividend.
	localparam logic [DATA_W-1:0] RECIP_60 = 32'h8888_8889;
	localparam logic [DATA_W-1:0] RECIP_24 = 32'hAAAA_AAAB;
	localparam int unsigned SHIFT_60 = 37;
	localparam int unsigned SHIFT_24 = 36;

	localparam logic [CFG_IDX_W-1:0] REG_MINUTES_WEST = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CMOS_WALL = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ADJUST = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SETTING_DISABLED = 8'd3;

	localparam logic [1:0] PASS_SEC = 2'd0;
	localparam logic [1:0] PASS_MIN = 2'd1;
	localparam logic [1:0] PASS_HOUR = 2'd2;

	localparam logic [6:0] DIV_SEC = 7'd60;
	localparam logic [6:0] DIV_HOUR = 7'd24;

	// The first day of 1970 was a Thursday: (0 + 4) mod 7.
	localparam logic [2:0] WD_EPOCH = 3'd4;
	localparam logic [3:0] MONTH_LAST = 4'd11;

	typedef struct packed {
		logic       load;
		logic       div_step;
		logic       div_last;
		logic [1:0] pass;
		logic       year_step;
		logic       month_step;
		logic       out_load;
	} ertc_cmd_t;

	typedef struct packed {
		logic disabled;
		logic year_fit;
		logic month_fit;
	} ertc_stat_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1:                   len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
			default:                len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [2:0] mod7(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		for (int i = 0; i < 5; i++) begin
			if (r >= 6'd7) begin
				r = r - 6'd7;
			end
		end
		return r[2:0];
	endfunction

	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [3:0] tens;
		logic [6:0] r;
		tens = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (v >= 7'(10 * i)) begin
				tens = 4'(i);
			end
		end
		r = v - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
		return {tens, r[3:0]};
	endfunction

endpackage

// ===== sv/ertc_ctrl.sv =====
// Controller for the epoch-seconds to RTC calendar converter.
// Sequences the divide passes, the year walk and the month walk.
// Depends on ertc_pkg.
module ertc_ctrl
	import ertc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  ertc_stat_t stat,
	output ertc_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_YEAR,
		ST_MONTH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       pass_q;
	logic             m_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

	always_comb begin
		cmd.load = s_tvalid && s_tready && !stat.disabled;
		cmd.div_step = (state_q == ST_DIV);
		cmd.div_last = (cnt_q == CNT_LAST);
		cmd.pass = pass_q;
		cmd.year_step = (state_q == ST_YEAR) && !stat.year_fit;
		cmd.month_step = (state_q == ST_MONTH) && !stat.month_fit;
		cmd.out_load = (state_q == ST_MONTH) && stat.month_fit && (!m_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			pass_q <= PASS_SEC;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_DIV;
						cnt_q <= '0;
						pass_q <= PASS_SEC;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cmd.div_last) begin
						if (pass_q == PASS_HOUR) begin
							state_q <= ST_YEAR;
						end else begin
							pass_q <= pass_q + 1'b1;
						end
					end
				end
				ST_YEAR: begin
					if (stat.year_fit) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/ertc_dp.sv =====
// Datapath for the epoch-seconds to RTC calendar converter.
// Holds the configuration registers, the reciprocal divider, the walks and the result register.
// Depends on ertc_pkg.
module ertc_dp
	import ertc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [DATA_W-1:0]     epoch_seconds,
	input  ertc_cmd_t             cmd,
	output ertc_stat_t            stat,
	output logic [RESULT_W-1:0]   result
);

	logic [10:0]       mw_q;
	logic              cmos_q;
	logic [17:0]       kadj_q;
	logic              dis_q;

	logic [DATA_W-1:0] div_q;
	logic [63:0]       prod_q;
	logic [5:0]        sec_q;
	logic [5:0]        min_q;
	logic [4:0]        hour_q;
	logic [DAYS_W-1:0] days_q;
	logic [7:0]        yoff_q;
	logic [3:0]        month_q;
	logic [2:0]        wd_q;
	logic [RESULT_W-1:0] result_q;

	logic [18:0]       mw_ext;
	logic [18:0]       offset;
	logic [DATA_W-1:0] tm;
	logic [6:0]        divisor;
	logic [DATA_W-1:0] recip;
	logic [DATA_W-1:0] quot;
	logic [7:0]        rem8;
	logic [5:0]        nrem;
	logic              leap;
	logic [DAYS_W-1:0] ylen;
	logic [4:0]        ml;
	logic [6:0]        yy;
	logic [6:0]        cent;
	logic [2:0]        weekday;
	logic [7:0]        year_b;
	logic [7:0]        cent_b;
	logic [7:0]        day_b;
	logic [7:0]        mon_b;
	logic [7:0]        hour_b;
	logic [7:0]        min_b;
	logic [7:0]        sec_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mw_q <= '0;
			cmos_q <= 1'b0;
			kadj_q <= '0;
			dis_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MINUTES_WEST:     mw_q <= cfg_data[10:0];
				REG_CMOS_WALL:        cmos_q <= cfg_data[0];
				REG_KERNEL_ADJUST:    kadj_q <= cfg_data;
				REG_SETTING_DISABLED: dis_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		mw_ext = {{8{mw_q[10]}}, mw_q};
		offset = (mw_ext << 6) - (mw_ext << 2) + (cmos_q ? {kadj_q[17], kadj_q} : 19'd0);
		tm = epoch_seconds - {{13{offset[18]}}, offset};

		divisor = (cmd.pass == PASS_HOUR) ? DIV_HOUR : DIV_SEC;
		recip = (cmd.pass == PASS_HOUR) ? RECIP_24 : RECIP_60;
		quot = (cmd.pass == PASS_HOUR) ? DATA_W'(prod_q >> SHIFT_24) :
			DATA_W'(prod_q >> SHIFT_60);
		// The remainder is below 64, so the low byte of the difference is exact.
		rem8 = div_q[7:0] - 8'(quot[7:0] * {1'b0, divisor});
		nrem = rem8[5:0];

		leap = (yoff_q[1:0] == 2'd2);
		ylen = DAYS_PLAIN + {{(DAYS_W-1){1'b0}}, leap};
		ml = month_len(month_q, leap);

		stat.disabled = dis_q;
		stat.year_fit = (days_q < ylen);
		stat.month_fit = (days_q < {{(DAYS_W-5){1'b0}}, ml}) || (month_q == MONTH_LAST);

		if (yoff_q < 8'd30) begin
			yy = 7'(yoff_q + 8'd70);
			cent = 7'd19;
		end else if (yoff_q < 8'd130) begin
			yy = 7'(yoff_q - 8'd30);
			cent = 7'd20;
		end else begin
			yy = 7'(yoff_q - 8'd130);
			cent = 7'd21;
		end
		year_b = to_bcd(yy);
		cent_b = to_bcd(cent);
		day_b = to_bcd(7'(days_q[4:0]) + 7'd1);
		mon_b = to_bcd({3'b000, month_q} + 7'd1);
		hour_b = to_bcd({2'b00, hour_q});
		min_b = to_bcd({1'b0, min_q});
		sec_b = to_bcd({1'b0, sec_q});
		weekday = mod7({3'b000, wd_q} + days_q[5:0]) + 3'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q <= tm;
			yoff_q <= '0;
			month_q <= '0;
			wd_q <= WD_EPOCH;
		end
		if (cmd.div_step) begin
			if (cmd.div_last) begin
				div_q <= quot;
				case (cmd.pass)
					PASS_SEC: sec_q <= nrem;
					PASS_MIN: min_q <= nrem;
					PASS_HOUR: begin
						hour_q <= nrem[4:0];
						days_q <= quot[DAYS_W-1:0];
					end
					default: begin
					end
				endcase
			end else begin
				prod_q <= {32'd0, div_q} * {32'd0, recip};
			end
		end
		if (cmd.year_step) begin
			days_q <= days_q - ylen;
			yoff_q <= yoff_q + 8'd1;
			wd_q <= mod7({3'b000, wd_q} + (leap ? 6'd2 : 6'd1));
		end
		if (cmd.month_step) begin
			days_q <= days_q - {{(DAYS_W-5){1'b0}}, ml};
			month_q <= month_q + 4'd1;
			wd_q <= mod7({3'b000, wd_q} + {1'b0, ml});
		end
		if (cmd.out_load) begin
			result_q <= {
				day_b[5:0],
				mon_b[4:0],
				cent_b[5:0],
				year_b,
				weekday,
				hour_b[5:0],
				min_b[6:0],
				sec_b[6:0]
			};
		end
	end

	assign result = result_q;

endmodule

// ===== sv/epoch_seconds_to_rtc_bcd.sv =====
// Converts a count of seconds since 1970-01-01 UTC, less the configured time zone offset,
// into BCD real-time-clock fields and a weekday (Sunday is 1). One request is worked on at a
// time: three divide passes by 60, 60 and 24 (each a reciprocal multiply and then a remainder
// step), a walk of one step per year from 1970 (up to 136) and a step to end that walk, one
// step per month walked (up to 11) and one to load the result, and a return to idle to take
// the next request. A finished result waits in an output register while the next request is
// taken; a further result is held back until that register is free. With setting_disabled
// set, requests are taken one per cycle and give no result. Every fourth year counts as a
// leap year, which holds through 2099.
module epoch_seconds_to_rtc_bcd
	import ertc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// Bits from the lowest up: epoch_seconds[31:0].
	input  logic [DATA_W-1:0]     s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// Bits from the lowest up: second_bcd[6:0], minute_bcd[13:7], hour_bcd[19:14],
	// weekday[22:20], year_bcd[30:23], century_bcd[36:31], month_bcd[41:37], day_bcd[47:42].
	output logic [RESULT_W-1:0]   m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ertc_cmd_t  cmd;
	ertc_stat_t stat;

	assign cfg_ready = 1'b1;

	ertc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ertc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.epoch_seconds (s_tdata),
		.cmd           (cmd),
		.stat          (stat),
		.result        (m_tdata)
	);

endmodule

// ===== sv/ertc_checker.sv =====
// Port-level checks for the epoch-seconds to RTC calendar converter.
// Bound to epoch_seconds_to_rtc_bcd; depends on ertc_pkg.
module ertc_checker
	import ertc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [RESULT_W-1:0]   m_tdata
);

	// A stalled result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// A new result appears only after the block was busy with a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a request in work");

	// A request accepted now cannot produce a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early after a request");

	// Weekday is never zero and the low BCD digits of seconds and day are legal.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[22:20] != 3'd0 && m_tdata[3:0] <= 4'd9 &&
			m_tdata[45:42] <= 4'd9)
		else $error("result fields out of range");

endmodule

bind epoch_seconds_to_rtc_bcd ertc_checker u_ertc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for epoch_seconds_to_rtc_bcd: drives epoch counts over the stream port,
// reprograms the time zone registers between phases and checks every BCD calendar result.
// Depends on ertc_pkg and the epoch_seconds_to_rtc_bcd top level.
module tb
	import ertc_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned SETTLE_CYCLES = 300;
	localparam int unsigned LONG_HOLD = 600;
	localparam int unsigned PHASES = 12;
	localparam int unsigned PHASE_ITEMS = 119;
	localparam int unsigned SECONDS_PER_DAY = 86400;
	localparam int unsigned PLAIN_YEAR_DAYS = 28 + 30 * 4 + 31 * 7;
	localparam int unsigned FIRST_YEAR = 1970;
	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_SETTING_DISABLED + 1'b1;

	// Offsets at and beyond the ends of the stated ranges, one per early phase.
	localparam int EDGE_MW [6] = '{-720, 840, -720, 1023, -1024, 840};
	localparam bit EDGE_WALL [6] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
	localparam int EDGE_KADJ [6] = '{0, 86400, -86400, 131071, -131072, -86400};

	typedef struct packed {
		logic [5:0] day;
		logic [4:0] month;
		logic [5:0] century;
		logic [7:0] year;
		logic [2:0] weekday;
		logic [5:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
	} rtc_date_t;

	typedef struct packed {
		logic      typed;
		rtc_date_t want;
		logic [31:0] epoch;
	} stim_row_t;

	localparam rtc_date_t DATE_EPOCH = '{day: 6'h01, month: 5'h01, century: 6'h19,
		year: 8'h70, weekday: 3'd5, hour: 6'h00, minute: 7'h00, second: 7'h00};
	localparam rtc_date_t DATE_DAY_TWO = '{day: 6'h02, month: 5'h01, century: 6'h19,
		year: 8'h70, weekday: 3'd6, hour: 6'h00, minute: 7'h00, second: 7'h00};
	localparam rtc_date_t DATE_Y2K = '{day: 6'h01, month: 5'h01, century: 6'h20,
		year: 8'h00, weekday: 3'd7, hour: 6'h00, minute: 7'h00, second: 7'h00};
	localparam rtc_date_t DATE_LAST = '{day: 6'h06, month: 5'h02, century: 6'h21,
		year: 8'h06, weekday: 3'd1, hour: 6'h06, minute: 7'h28, second: 7'h15};

	localparam stim_row_t DIRECTED [21] = '{
		'{1'b1, DATE_EPOCH, 32'd0},
		'{1'b0, '0, 32'd59},
		'{1'b0, '0, 32'd60},
		'{1'b0, '0, 32'd3599},
		'{1'b0, '0, 32'd3600},
		'{1'b0, '0, 32'd86399},
		'{1'b1, DATE_DAY_TWO, 32'd86400},
		'{1'b0, '0, 32'd68255999},
		'{1'b0, '0, 32'd68256000},
		'{1'b0, '0, 32'd946684799},
		'{1'b1, DATE_Y2K, 32'd946684800},
		'{1'b0, '0, 32'd951782400},
		'{1'b0, '0, 32'd978307199},
		'{1'b0, '0, 32'd4102444800},
		'{1'b0, '0, 32'd4107542400},
		'{1'b0, '0, 32'd4107628800},
		'{1'b0, '0, 32'h7FFFFFFF},
		'{1'b0, '0, 32'h80000000},
		'{1'b0, '0, 32'h55555555},
		'{1'b0, '0, 32'hAAAAAAAA},
		'{1'b1, DATE_LAST, 32'hFFFFFFFF}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [RESULT_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [10:0] cfg_mw = '0;
	logic cfg_wall = 1'b0;
	logic [17:0] cfg_kadj = '0;
	logic cfg_off = 1'b0;

	rtc_date_t pending_dates [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned hold_left = 0;
	int unsigned press_req = 0;
	int unsigned press_seen = 0;
	logic quiet = 1'b0;
	bit bursty;

	epoch_seconds_to_rtc_bcd DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] bcd_pair(input int unsigned v);
		return {4'((v / 10) % 10), 4'(v % 10)};
	endfunction

	function automatic int local_offset();
		int offset;
		offset = $signed(cfg_mw) * 60;
		if (cfg_wall) begin
			offset += $signed(cfg_kadj);
		end
		return offset;
	endfunction

	function automatic int unsigned year_days(input int unsigned y);
		return PLAIN_YEAR_DAYS + ((y % 4 == 0) ? 1 : 0);
	endfunction

	function automatic rtc_date_t calendar_of(input logic [31:0] epoch);
		rtc_date_t r;
		logic [31:0] t;
		int unsigned days;
		int unsigned y;
		int unsigned mon;
		int unsigned mlen;
		t = epoch - 32'(local_offset());
		r.second = 7'(bcd_pair(t % 60));
		t = t / 60;
		r.minute = 7'(bcd_pair(t % 60));
		t = t / 60;
		r.hour = 6'(bcd_pair(t % 24));
		days = t / 24;
		r.weekday = 3'((days + 4) % 7 + 1);
		y = FIRST_YEAR;
		while (days >= year_days(y)) begin
			days -= year_days(y);
			y++;
		end
		r.year = bcd_pair(y % 100);
		r.century = 6'(bcd_pair(y / 100));
		mon = 0;
		mlen = MONTH_DAYS[0];
		while (mon < 11 && days >= mlen) begin
			days -= mlen;
			mon++;
			mlen = MONTH_DAYS[mon] + ((mon == 1 && y % 4 == 0) ? 1 : 0);
		end
		r.month = 5'(bcd_pair(mon + 1));
		r.day = 6'(bcd_pair(days + 1));
		return r;
	endfunction

	// Local times that land on day, month and year edges are favored over plain noise.
	function automatic logic [31:0] pick_epoch();
		int unsigned y;
		int unsigned d;
		int unsigned s;
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			4, 5, 6: begin
				y = $urandom_range(FIRST_YEAR, 2105);
				d = 0;
				for (int unsigned yy = FIRST_YEAR; yy < y; yy++) begin
					d += year_days(yy);
				end
				case ($urandom_range(0, 5))
					0: d += 0;
					1: d += 58;
					2: d += 59;
					3: d += 60;
					4: d += year_days(y) - 1;
					default: d += $urandom_range(0, 364);
				endcase
				case ($urandom_range(0, 2))
					0: s = 0;
					1: s = SECONDS_PER_DAY - 1;
					default: s = $urandom_range(0, SECONDS_PER_DAY - 1);
				endcase
				v = 32'(d * SECONDS_PER_DAY + s) + 32'(local_offset());
			end
			7: v = $urandom_range(0, 200000);
			8: v = 32'hFFFFFFFF - $urandom_range(0, 200000);
			9: v = $urandom & $urandom;
			default: ;
		endcase
		return v;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : sink
		rtc_date_t got;
		rtc_date_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_dates.size() == 0) begin
					$error("Result arrived with no request outstanding.");
					mismatches++;
				end else begin
					want = pending_dates.pop_front();
					check_field("second_bcd", want.second, got.second);
					check_field("minute_bcd", want.minute, got.minute);
					check_field("hour_bcd", want.hour, got.hour);
					check_field("weekday", want.weekday, got.weekday);
					check_field("year_bcd", want.year, got.year);
					check_field("century_bcd", want.century, got.century);
					check_field("month_bcd", want.month, got.month);
					check_field("day_bcd", want.day, got.day);
				end
			end
			if (press_req != press_seen) begin
				press_seen <= press_req;
				hold_left <= LONG_HOLD;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold_left <= $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MINUTES_WEST: cfg_mw = val[10:0];
			REG_CMOS_WALL: cfg_wall = val[0];
			REG_KERNEL_ADJUST: cfg_kadj = val;
			REG_SETTING_DISABLED: cfg_off = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int mw, input bit wall, input int kadj);
		write_reg(REG_SETTING_DISABLED, {17'($urandom), 1'b0});
		write_reg(REG_MINUTES_WEST, {7'($urandom), 11'(mw)});
		if ($urandom_range(0, 2) == 0) begin
			write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, 255)), 18'($urandom));
		end
		write_reg(REG_CMOS_WALL, {17'($urandom), wall});
		write_reg(REG_KERNEL_ADJUST, 18'(kadj));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_epoch(input logic [31:0] epoch, input bit typed, input rtc_date_t want);
		int unsigned gap;
		gap = 0;
		if (bursty && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= epoch;
		do @(posedge clk); while (!s_tready);
		if (!cfg_off) begin
			pending_dates.push_back(typed ? want : calendar_of(epoch));
		end
	endtask

	// A request taken while results are suppressed starts no work and gives no result; settle
	// waits until the queue runs dry, then keeps s_tvalid low a while before anything changes.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		bursty = 1'b1;
		foreach (DIRECTED[i]) begin
			send_epoch(DIRECTED[i].epoch, DIRECTED[i].typed, DIRECTED[i].want);
		end

		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == PHASES / 2) begin
				write_reg(REG_SETTING_DISABLED, {17'($urandom), 1'b1});
				cfg_valid <= 1'b0;
				for (int unsigned k = 0; k < 12; k++) begin
					send_epoch(pick_epoch(), 1'b0, '0);
				end
				settle();
			end
			if (ph < 6) begin
				apply_setting(EDGE_MW[ph], EDGE_WALL[ph], EDGE_KADJ[ph]);
			end else begin
				apply_setting(int'($urandom_range(0, 1560)) - 720, 1'($urandom),
					int'($urandom_range(0, 172800)) - 86400);
			end
			bursty = (ph != 0 && ph != PHASES - 1 && $urandom_range(0, 3) != 0);
			if (ph == 0) begin
				press_req <= press_req + 1;
			end
			if (ph == PHASES - 1) begin
				quiet <= 1'b1;
			end
			for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
				send_epoch(pick_epoch(), 1'b0, '0);
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
